/* design/bb3_pkg.sv */
package bb3_pkg;

    // Line store depth and the widths that follow from it
    localparam int MAX_WIDTH  = 1024;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int MAX_HEIGHT = 1024;
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // Field widths
    localparam int COORD_W = 10;
    localparam int CFG_W   = 11;
    localparam int PIX_W   = 32;
    localparam int RGB_W   = 24;
    localparam int SUM_W   = 12;

    // Width of the effective frame width register: holds MAX_WIDTH and any written value
    localparam int WID_W = (ADDR_W + 1 > CFG_W) ? ADDR_W + 1 : CFG_W;
    localparam int HGT_W = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;

    // Register indexes of the configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam int RESET_WIDTH  = 800;
    localparam int RESET_HEIGHT = 600;

    // Reciprocal of 9 in 0.16 fixed point, exact for sums up to 9 * 255
    localparam int DIV9_MUL   = 7282;
    localparam int DIV9_SHIFT = 16;
    localparam int PROD_W     = SUM_W + 13;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef logic [RGB_W-1:0] t_rgb;
    typedef logic [SUM_W-1:0] t_sum;

    function automatic logic [7:0] div9(input t_sum s);
        logic [PROD_W-1:0] p;
        p = PROD_W'(s) * PROD_W'(DIV9_MUL);
        return p[DIV9_SHIFT+7:DIV9_SHIFT];
    endfunction

endpackage

/* design/box_blur_3x3_rgba.sv */
// 3x3 box blur over an RGBA8888 frame streamed in raster order.
// Input channel: i_pixel with i_in_valid / o_in_stall; a transaction moves one pixel.
// Output channel: o_out_x, o_out_y, o_color, o_last with o_out_valid / i_out_stall;
// a transaction moves one blurred pixel, o_last marking the final result of a pixel.
// Configuration: i_cfg_index / i_cfg_data with i_cfg_valid / o_cfg_ready (always
// ready). Index 0 sets frame width, index 1 frame height; either write restarts
// the frame at column 0, row 0. Write only while the block is idle.
// Throughput: one pixel per clock while the output is not stalled. A pixel causing
// more than one result (up to 4, at the last column and last row) holds the emit
// stage until its last result leaves, and the input stalls meanwhile; the emit stage
// and the one-read-port line stores set this figure. Path: the first result of a
// pixel passes the read stage and emit stage, then the output register.
// Reset: counters at zero, frame 800 x 600, pipeline empty. The line stores are not
// cleared; entries of rows not yet received are masked out of every sum.
// When the receiver stalls, the output register holds its transaction and the
// pipeline behind it fills, then o_in_stall rises.
module box_blur_3x3_rgba
    import bb3_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // pixel input
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [PIX_W-1:0]     i_pixel,
    // blurred output
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [COORD_W-1:0]   o_out_x,
    output logic [COORD_W-1:0]   o_out_y,
    output logic [PIX_W-1:0]     o_color,
    output logic                 o_last,
    // configuration write
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // Configuration and position counters
    logic [WID_W-1:0]  r_width;
    logic [HGT_W-1:0]  r_height;
    logic [ADDR_W-1:0] r_col;
    logic [ROW_W-1:0]  r_row;

    // Read stage: pixel waiting for its line store data
    logic              r_s1_valid;
    t_rgb              r_s1_rgb;
    logic [ADDR_W-1:0] r_s1_x;
    logic [ROW_W-1:0]  r_s1_y;

    // Forwarding of a write that collided with the read (single-column frames)
    logic              r_fwd;
    t_rgb              r_fwd_near;
    t_rgb              r_fwd_far;

    // 3x3 window, [row far/near/current][column x-2..x]
    t_rgb              r_win [3][3];

    // Emit stage: results still owed for the window's pixel
    logic              r_s2_valid;
    logic [3:0]        r_s2_mask;
    logic [ADDR_W-1:0] r_s2_x;
    logic [ROW_W-1:0]  r_s2_y;
    logic              r_s2_xge1;
    logic              r_s2_xge2;
    logic              r_s2_yge1;
    logic              r_s2_yge2;

    // Output register: sums are held and divided on the way out
    logic               r_out_valid;
    logic [COORD_W-1:0] r_out_x;
    logic [COORD_W-1:0] r_out_y;
    t_sum               r_out_sr;
    t_sum               r_out_sg;
    t_sum               r_out_sb;
    logic               r_out_last;

    logic accept;
    logic cfg_we;
    logic out_free;
    logic emit;
    logic s2_done;
    logic s2_free;
    logic s1_adv;

    t_rgb ram_near_q;
    t_rgb ram_far_q;
    t_rgb near_val;
    t_rgb far_val;

    logic [3:0] s1_mask;
    logic       s1_xlast;
    logic       s1_ylast;
    logic       fwd_hit;

    logic [3:0] pick;
    logic [3:0] rest;
    logic       dc;
    logic       dr;
    logic [2:0] row_ok;
    logic [2:0] col_ok;
    t_sum       sum_r;
    t_sum       sum_g;
    t_sum       sum_b;
    logic [ADDR_W-1:0] emit_c;
    logic [ROW_W-1:0]  emit_r;

    logic [CFG_W-1:0] eff_w;
    logic [CFG_W-1:0] eff_h;

    // ---------------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------------
    assign out_free    = !r_out_valid || !i_out_stall;
    assign emit        = r_s2_valid && out_free;
    assign s2_done     = emit && (rest == 4'd0);
    assign s2_free     = !r_s2_valid || s2_done;
    assign s1_adv      = r_s1_valid && s2_free;
    assign o_in_stall  = r_s1_valid && !s2_free;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // Zero counts as one; saturate to the line store depth and the row limit
    always_comb begin
        eff_w = i_cfg_data;
        if (i_cfg_data == '0) begin
            eff_w = CFG_W'(1);
        end else if (WID_W'(i_cfg_data) > WID_W'(MAX_WIDTH)) begin
            eff_w = CFG_W'(MAX_WIDTH);
        end
        eff_h = i_cfg_data;
        if (i_cfg_data == '0) begin
            eff_h = CFG_W'(1);
        end else if (HGT_W'(i_cfg_data) > HGT_W'(MAX_HEIGHT)) begin
            eff_h = CFG_W'(MAX_HEIGHT);
        end
    end

    // ---------------------------------------------------------------------
    // Line stores: read at accept, write back when the read stage advances
    // ---------------------------------------------------------------------
    bb3_ram #(
        .WIDTH (RGB_W),
        .DEPTH (MAX_WIDTH)
    ) u_near (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_x),
        .i_wdata (r_s1_rgb),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (ram_near_q)
    );

    bb3_ram #(
        .WIDTH (RGB_W),
        .DEPTH (MAX_WIDTH)
    ) u_far (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_x),
        .i_wdata (near_val),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (ram_far_q)
    );

    // The read misses a write to the same column in the same cycle: bypass it
    assign near_val = r_fwd ? r_fwd_near : ram_near_q;
    assign far_val  = r_fwd ? r_fwd_far  : ram_far_q;
    assign fwd_hit  = s1_adv && (r_col == r_s1_x);

    // Results owed by the pixel in the read stage, in raster order:
    // (x-1,y-1), (x,y-1), (x-1,y), (x,y)
    assign s1_xlast = (WID_W'(r_s1_x) + WID_W'(1)) == r_width;
    assign s1_ylast = (HGT_W'(r_s1_y) + HGT_W'(1)) == r_height;
    assign s1_mask[0] = (r_s1_x != '0) && (r_s1_y != '0);
    assign s1_mask[1] = s1_xlast && (r_s1_y != '0);
    assign s1_mask[2] = s1_ylast && (r_s1_x != '0);
    assign s1_mask[3] = s1_xlast && s1_ylast;

    // ---------------------------------------------------------------------
    // Emit stage: one result per cycle while the output register is free, lowest owed first
    // ---------------------------------------------------------------------
    assign pick = r_s2_mask & (~r_s2_mask + 4'd1);
    assign rest = r_s2_mask & ~pick;
    assign dc   = pick[1] || pick[3];
    assign dr   = pick[2] || pick[3];

    // Window rows and columns inside the frame and next to the chosen pixel
    assign row_ok = {1'b1, r_s2_yge1, !dr && r_s2_yge2};
    assign col_ok = {1'b1, r_s2_xge1, !dc && r_s2_xge2};

    always_comb begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (row_ok[i] && col_ok[j]) begin
                    sum_r = sum_r + SUM_W'(r_win[i][j][23:16]);
                    sum_g = sum_g + SUM_W'(r_win[i][j][15:8]);
                    sum_b = sum_b + SUM_W'(r_win[i][j][7:0]);
                end
            end
        end
    end

    assign emit_c = dc ? r_s2_x : r_s2_x - ADDR_W'(1);
    assign emit_r = dr ? r_s2_y : r_s2_y - ROW_W'(1);

    // ---------------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WID_W'(RESET_WIDTH);
            r_height    <= HGT_W'(RESET_HEIGHT);
            r_col       <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd       <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s2_mask   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_we && (i_cfg_index == CFG_FRAME_WIDTH
                           || i_cfg_index == CFG_FRAME_HEIGHT)) begin
                if (i_cfg_index == CFG_FRAME_WIDTH) begin
                    r_width <= WID_W'(eff_w);
                end else begin
                    r_height <= HGT_W'(eff_h);
                end
                // restart the frame
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                if (WID_W'(r_col) + WID_W'(1) >= r_width) begin
                    r_col <= '0;
                    if (HGT_W'(r_row) + HGT_W'(1) >= r_height) begin
                        r_row <= '0;
                    end else begin
                        r_row <= r_row + ROW_W'(1);
                    end
                end else begin
                    r_col <= r_col + ADDR_W'(1);
                end
            end

            if (accept) begin
                r_s1_valid <= 1'b1;
                r_fwd      <= fwd_hit;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            // Pixels that owe nothing only update the window
            if (s1_adv) begin
                r_s2_valid <= (s1_mask != 4'd0);
                r_s2_mask  <= s1_mask;
            end else if (emit) begin
                r_s2_valid <= (rest != 4'd0);
                r_s2_mask  <= rest;
            end

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_rgb   <= i_pixel[31:8];
            r_s1_x     <= r_col;
            r_s1_y     <= r_row;
            r_fwd_near <= r_s1_rgb;
            r_fwd_far  <= near_val;
        end

        if (s1_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= far_val;
            r_win[1][2] <= near_val;
            r_win[2][2] <= r_s1_rgb;
            r_s2_x      <= r_s1_x;
            r_s2_y      <= r_s1_y;
            r_s2_xge1   <= (r_s1_x != '0);
            r_s2_xge2   <= (r_s1_x > ADDR_W'(1));
            r_s2_yge1   <= (r_s1_y != '0);
            r_s2_yge2   <= (r_s1_y > ROW_W'(1));
        end

        if (emit) begin
            r_out_x    <= COORD_W'(emit_c);
            r_out_y    <= COORD_W'(emit_r);
            r_out_sr   <= sum_r;
            r_out_sg   <= sum_g;
            r_out_sb   <= sum_b;
            r_out_last <= (rest == 4'd0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_last      = r_out_last;
    assign o_color     = {div9(r_out_sr), div9(r_out_sg), div9(r_out_sb), ALPHA_OPAQUE};

endmodule

/* design/bb3_ram.sv */
module bb3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data between reads
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bb3_pkg::*;

    // Run control
    localparam int DRAIN_CYCLES = 8;       // comfortably past the read, emit and output stages
    localparam int LONG_HOLD    = 200;     // receiver hold-off, long enough to back the block up
    localparam int RAND_ITEMS   = 110;
    localparam int SETTLE_LIMIT = 50000;
    localparam int RUN_LIMIT_NS = 4_000_000;

    // Register indexes past the end of the list: the block must ignore them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // One blurred pixel as it leaves the block
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIX_W-1:0]   color;
        logic               last;
    } blurred_t;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic [PIX_W-1:0]     i_pixel     = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [COORD_W-1:0]   o_out_x;
    logic [COORD_W-1:0]   o_out_y;
    logic [PIX_W-1:0]     o_color;
    logic                 o_last;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    box_blur_3x3_rgba dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_pixel     (i_pixel),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_color     (o_color),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Pixels waiting to be offered, and blurred pixels the block still owes us
    logic [PIX_W-1:0] pending_pixels[$];
    blurred_t         blurred_due[$];

    // Idle percentages per side; the stimulus moves them through the three idling modes
    int tx_idle_pct = 37;
    int rx_idle_pct = 82;

    logic rx_hold = 1'b0;
    event rx_hold_ev;

    int n_errors   = 0;
    int n_pixels   = 0;
    int n_results  = 0;
    int n_settings = 0;

    // Own copy of the blur state: two line stores, the 3x3 window, position and frame size
    t_rgb             line_near [MAX_WIDTH];
    t_rgb             line_far  [MAX_WIDTH];
    t_rgb             win       [3][3];
    int               next_col;
    int               next_row;
    logic [CFG_W-1:0] reg_width;
    logic [CFG_W-1:0] reg_height;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string msg);
        n_errors++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // Zero and oversized frame sizes collapse onto the legal range
    function automatic int clip_size(input logic [CFG_W-1:0] v, input int top);
        if (v < 1)
            return 1;
        if (v > top)
            return top;
        return v;
    endfunction

    task automatic predictor_reset();
        for (int i = 0; i < MAX_WIDTH; i++) begin
            line_near[i] = '0;
            line_far[i]  = '0;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                win[i][j] = '0;
        next_col   = 0;
        next_row   = 0;
        reg_width  = CFG_W'(RESET_WIDTH);
        reg_height = CFG_W'(RESET_HEIGHT);
    endtask

    // A write to either size register restarts the frame; spare indexes change nothing
    task automatic predictor_config(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] val);
        case (idx)
            CFG_FRAME_WIDTH: begin
                reg_width = val;
                next_col  = 0;
                next_row  = 0;
            end
            CFG_FRAME_HEIGHT: begin
                reg_height = val;
                next_col   = 0;
                next_row   = 0;
            end
            default: ;
        endcase
    endtask

    // Blurred colour of pixel (c, r) from the window whose newest corner is (x, y);
    // neighbours outside the frame add nothing
    function automatic logic [PIX_W-1:0] blur_of(input int c, input int r,
                                                 input int x, input int y);
        int   sr, sg, sb, yy, xx;
        t_rgb v;
        sr = 0;
        sg = 0;
        sb = 0;
        for (int i = 0; i < 3; i++) begin
            yy = y - 2 + i;
            if (yy >= 0 && yy >= r - 1 && yy <= r + 1)
                for (int j = 0; j < 3; j++) begin
                    xx = x - 2 + j;
                    if (xx >= 0 && xx >= c - 1 && xx <= c + 1) begin
                        v  = win[i][j];
                        sr += v[23:16];
                        sg += v[15:8];
                        sb += v[7:0];
                    end
                end
        end
        return {8'(sr / 9), 8'(sg / 9), 8'(sb / 9), ALPHA_OPAQUE};
    endfunction

    // Advance the window by one accepted pixel and queue the blurred pixels it releases that lie
    // in the frame: (x-1,y-1), (x,y-1) on the last column, and row y itself on the last row
    task automatic blur_predict(input logic [PIX_W-1:0] px);
        int       w, h, x, y, r, c, n;
        blurred_t found [4];
        blurred_t e;
        w = clip_size(reg_width, MAX_WIDTH);
        h = clip_size(reg_height, MAX_HEIGHT);
        x = (next_col >= w) ? w - 1 : next_col;
        y = (next_row >= h) ? h - 1 : next_row;

        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2]    = line_far[x];
        win[1][2]    = line_near[x];
        win[2][2]    = px[31:8];
        line_far[x]  = line_near[x];
        line_near[x] = px[31:8];

        n = 0;
        for (int dr = 0; dr < 2; dr++) begin
            r = y - 1 + dr;
            if ((dr == 0 || y == h - 1) && r >= 0)
                for (int dc = 0; dc < 2; dc++) begin
                    c = x - 1 + dc;
                    if ((dc == 0 || x == w - 1) && c >= 0) begin
                        found[n] = {COORD_W'(c), COORD_W'(r), blur_of(c, r, x, y), 1'b0};
                        n++;
                    end
                end
        end
        for (int k = 0; k < n; k++) begin
            e      = found[k];
            e.last = (k == n - 1);
            blurred_due.push_back(e);
        end

        // Wrap the column at the row end and the row at the frame end
        if (x + 1 >= w) begin
            next_col = 0;
            next_row = (y + 1 >= h) ? 0 : y + 1;
        end else begin
            next_col = x + 1;
            next_row = y;
        end
    endtask

    // Pixel driver: track configuration writes, predict every accepted transaction, then offer the next pixel unless
    // the sender idles this cycle. A stalled pixel is held as it is.
    always @(posedge i_clk) begin : pixel_driver
        logic took;
        took = i_in_valid && !o_in_stall;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            predictor_reset();
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                predictor_config(i_cfg_index, i_cfg_data);
            if (took) begin
                blur_predict(i_pixel);
                n_pixels++;
            end
            if (!i_in_valid || took) begin
                if (pending_pixels.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_pixel    <= pending_pixels.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_blurred();
        blurred_t e;
        n_results++;
        if (blurred_due.size() == 0) begin
            flag_mismatch($sformatf("result (%0d,%0d) color %h last %b with nothing expected",
                                    o_out_x, o_out_y, o_color, o_last));
        end else begin
            e = blurred_due.pop_front();
            if (o_out_x !== e.x)
                flag_mismatch($sformatf("out_x %0d, expected %0d", o_out_x, e.x));
            if (o_out_y !== e.y)
                flag_mismatch($sformatf("out_y %0d, expected %0d", o_out_y, e.y));
            if (o_color !== e.color)
                flag_mismatch($sformatf("color %h at (%0d,%0d), expected %h",
                                        o_color, e.x, e.y, e.color));
            if (o_last !== e.last)
                flag_mismatch($sformatf("last %b at (%0d,%0d), expected %b",
                                        o_last, e.x, e.y, e.last));
        end
    endtask

    // Result monitor: check each accepted transaction, then pick the next stall
    always @(posedge i_clk) begin : blur_monitor
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall)
                check_blurred();
            if (rx_hold)
                i_out_stall <= 1'b1;
            else
                i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Long receiver hold-off, counted here so the sender keeps offering meanwhile
    initial begin : rx_hold_off
        forever begin
            @(rx_hold_ev);
            @(negedge i_clk);
            rx_hold = 1'b1;
            repeat (LONG_HOLD) @(negedge i_clk);
            rx_hold = 1'b0;
        end
    end

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_pixels(input int count);
        repeat (count) pending_pixels.push_back(rand_pixel());
    endtask

    // Wait until every pixel is in and every result out, then let the pipeline drain of
    // pixels that released nothing
    task automatic settle();
        int waited;
        waited = 0;
        while ((pending_pixels.size() != 0 || i_in_valid || blurred_due.size() != 0)
               && waited < SETTLE_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Idle the block, then set a new frame size in a random register order
    task automatic frame_setup(input int w, input int h);
        settle();
        if ($urandom_range(1) == 0) begin
            write_reg(CFG_FRAME_WIDTH, CFG_W'(w));
            write_reg(CFG_FRAME_HEIGHT, CFG_W'(h));
        end else begin
            write_reg(CFG_FRAME_HEIGHT, CFG_W'(h));
            write_reg(CFG_FRAME_WIDTH, CFG_W'(w));
        end
        @(negedge i_clk);
        n_settings++;
    endtask

    initial begin : stimulus
        int w, h, n, split, rand_items;
        rand_items = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: saturated white and black frames; corners, edges and centre all differ
        frame_setup(3, 3);
        repeat (9) pending_pixels.push_back('1);
        repeat (9) pending_pixels.push_back('0);

        // Zero sizes act as a 1x1 frame: every pixel is a whole frame, alpha ignored
        frame_setup(0, 0);
        pending_pixels.push_back(32'hFFFF_FF00);
        pending_pixels.push_back(32'h0000_00FF);

        // Spare indexes mid-frame: no restart, so the frame must complete as if untouched
        frame_setup(2, 2);
        send_pixels(2);
        settle();
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, '0);
        @(negedge i_clk);
        send_pixels(2);

        // Hold the receiver off while a frame streams in, so the input stalls
        frame_setup(8, 6);
        -> rx_hold_ev;
        send_pixels(48);
        rand_items += 48;

        // Random frames, mostly small, often cut short or paused mid-frame
        while (rand_items < RAND_ITEMS) begin
            if (rand_items >= 2 * RAND_ITEMS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (rand_items >= RAND_ITEMS / 3) begin
                tx_idle_pct = 82;
                rx_idle_pct = 37;
            end
            w = $urandom_range(1, 10);
            h = $urandom_range(1, 6);
            if ($urandom_range(9) == 0)
                w = $urandom_range(0, 2047);
            frame_setup(w, h);
            n = $urandom_range(1, (w * h < 20) ? 2 * w * h + 1 : 40);
            if ($urandom_range(3) == 0 && n > 1) begin
                // pause the sender until the block has handed back everything so far
                split = n / 2;
                send_pixels(split);
                settle();
                send_pixels(n - split);
            end else begin
                send_pixels(n);
            end
            rand_items += n;
        end

        // Saturated sizes: a row clipped to the line store depth, then a column clipped
        // to the row limit
        frame_setup(2047, 0);
        send_pixels(8);
        frame_setup(0, 2047);
        send_pixels(8);

        settle();
        if (pending_pixels.size() != 0 || i_in_valid)
            flag_mismatch("pixels offered but never accepted");
        if (blurred_due.size() != 0)
            flag_mismatch($sformatf("%0d expected results never arrived", blurred_due.size()));

        $display("covered %0d pixels over %0d frame sizes from 1x1 up, zero and saturated sizes,",
                 n_pixels, n_settings);
        $display("spare indexes and a long receiver hold-off; %0d results checked, %0d mismatches",
                 n_results, n_errors);
        if (n_errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("watchdog expired with %0d results outstanding", blurred_due.size());
        $display("tb failed");
        $finish;
    end

endmodule
